FILE: rtl/core/dxt_pkg.sv
// shared types, codes and divide helpers for the block decoder
`default_nettype none
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } dxt_format_t;

  localparam logic REG_BLOCK_FORMAT = 1'b0;
  localparam logic REG_CHANNEL_MASK = 1'b1;

  localparam int MASK_RED   = 0;
  localparam int MASK_GREEN = 1;
  localparam int MASK_BLUE  = 2;
  localparam int MASK_ALPHA = 3;

  localparam logic [3:0] LAST_TEXEL = 4'd15;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [63:0] colour_word;
    logic [63:0] alpha_word;
  } dxt_request_t;

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_texel;
  } dxt_result_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] colour;  // entry, channel (0 red, 1 green, 2 blue)
    logic [7:0][7:0]      alpha;   // interpolated alpha levels
    logic                 three;   // three-colour mode, entry 3 transparent
  } dxt_palette_t;

  // x / 3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // x / 7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dxt_block_decoder.sv
// Each request passes the input register, the palette stage and the texel
// output register; the sixteen texels of a block follow back to back.
// One block at a time goes out through the single texel output port;
// the next request is taken while the current block is still streaming out.
// Reset (synchronous): pipeline emptied, block_format 0, channel_mask 15.
`default_nettype none
module dxt_block_decoder
  import dxt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire dxt_request_t block,
  output logic        texel_valid,
  output dxt_result_t texel,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic [1:0] block_format;
  logic [3:0] channel_mask;

  dxt_request_t blk;
  logic         blk_valid;

  dxt_palette_t pal;
  dxt_palette_t pal_next;
  logic [31:0]  cidx;
  logic [63:0]  aword;
  logic         pal_valid;
  logic [3:0]   cnt;

  logic         accept;
  logic         pal_load;
  logic         dxt1;
  dxt_result_t  texel_next;

  assign pal_load = blk_valid && (!pal_valid || cnt == LAST_TEXEL);
  assign busy     = blk_valid && !pal_load;
  assign accept   = start && !busy;

  always_comb begin
    case (block_format)
      FMT_DXT3: dxt1 = 1'b0;
      FMT_DXT5: dxt1 = 1'b0;
      default:  dxt1 = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
      channel_mask <= 4'hF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_FORMAT: block_format <= cfg_data[1:0];
        REG_CHANNEL_MASK: channel_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (accept) begin
      blk_valid <= 1'b1;
    end else if (pal_load) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk <= block;
    end
  end

  dxt_palette u_palette (
    .endpoints  (blk.colour_word[31:0]),
    .alpha_ends (blk.alpha_word[15:0]),
    .dxt1       (dxt1),
    .palette    (pal_next)
  );

  // palette stage, streams sixteen texels
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= 1'b0;
      cnt       <= 4'd0;
    end else if (pal_load) begin
      pal_valid <= 1'b1;
      cnt       <= 4'd0;
    end else if (pal_valid) begin
      if (cnt == LAST_TEXEL) begin
        pal_valid <= 1'b0;
        cnt       <= 4'd0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_load) begin
      pal   <= pal_next;
      cidx  <= blk.colour_word[63:32];
      aword <= blk.alpha_word;
    end
  end

  // texel select
  always_comb begin
    logic [1:0] ci;
    logic [3:0] nib;
    logic [5:0] aoff;
    logic [2:0] ai;
    logic [7:0] a;
    ci   = cidx[{cnt, 1'b0} +: 2];
    nib  = aword[{cnt, 2'b00} +: 4];
    aoff = 6'd16 + {2'b00, cnt} + {1'b0, cnt, 1'b0};
    ai   = aword[aoff +: 3];
    case (block_format)
      FMT_DXT3: a = {nib, nib};
      FMT_DXT5: a = pal.alpha[ai];
      default:  a = (pal.three && ci == 2'd3) ? 8'd0 : ALPHA_OPAQUE;
    endcase
    texel_next.texel_index = cnt;
    texel_next.red   = channel_mask[MASK_RED]   ? pal.colour[ci][0] : 8'd0;
    texel_next.green = channel_mask[MASK_GREEN] ? pal.colour[ci][1] : 8'd0;
    texel_next.blue  = channel_mask[MASK_BLUE]  ? pal.colour[ci][2] : 8'd0;
    texel_next.alpha = channel_mask[MASK_ALPHA] ? a : ALPHA_OPAQUE;
    texel_next.last_texel = (cnt == LAST_TEXEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= pal_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_valid) begin
      texel <= texel_next;
    end
  end

`ifndef SYNTHESIS
  a_texel_order: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !texel.last_texel |=>
      texel_valid && texel.texel_index == $past(texel.texel_index) + 4'd1)
    else $error("texel sequence broken inside a block");

  a_stream_follows: assert property (@(posedge clk) disable iff (rst)
    pal_valid |=> texel_valid && texel.texel_index == $past(cnt))
    else $error("palette stage did not produce a texel");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !pal_valid |-> cnt == 4'd0)
    else $error("texel counter running with no block loaded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> !blk_valid || pal_load)
    else $error("request taken over a held block");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/dxt_palette.sv
// colour and alpha palette builder for one block
`default_nettype none
module dxt_palette
  import dxt_pkg::*;
(
  input  wire logic [31:0] endpoints,
  input  wire logic [15:0] alpha_ends,
  input  wire logic        dxt1,
  output dxt_palette_t     palette
);

  logic [15:0] ea;
  logic [15:0] eb;
  logic [2:0][7:0] ca;
  logic [2:0][7:0] cb;
  logic [7:0] a0;
  logic [7:0] a1;
  logic three;
  logic [7:0][7:0] lvl5;
  logic [7:0][7:0] lvl7;

  assign ea = endpoints[15:0];
  assign eb = endpoints[31:16];
  assign a0 = alpha_ends[7:0];
  assign a1 = alpha_ends[15:8];
  assign three = dxt1 && (ea <= eb);

  assign ca[0] = expand5(ea[15:11]);
  assign ca[1] = expand6(ea[10:5]);
  assign ca[2] = expand5(ea[4:0]);
  assign cb[0] = expand5(eb[15:11]);
  assign cb[1] = expand6(eb[10:5]);
  assign cb[2] = expand5(eb[4:0]);

  genvar g;
  for (g = 0; g < 3; g++) begin : g_chan
    logic [8:0] mean_sum;
    logic [9:0] near_a;
    logic [9:0] near_b;
    assign mean_sum = {1'b0, ca[g]} + {1'b0, cb[g]};
    assign near_a = {1'b0, ca[g], 1'b0} + {2'b00, cb[g]};
    assign near_b = {2'b00, ca[g]} + {1'b0, cb[g], 1'b0};
    assign palette.colour[0][g] = ca[g];
    assign palette.colour[1][g] = cb[g];
    assign palette.colour[2][g] = three ? mean_sum[8:1] : div3(near_a);
    assign palette.colour[3][g] = three ? 8'd0 : div3(near_b);
  end

  assign lvl5[0] = a0;
  assign lvl5[1] = a1;
  assign lvl5[6] = 8'd0;
  assign lvl5[7] = ALPHA_OPAQUE;
  for (g = 1; g < 5; g++) begin : g_lvl5
    logic [10:0] s5;
    assign s5 = 11'(5 - g) * {3'b000, a0} + 11'(g) * {3'b000, a1};
    assign lvl5[g + 1] = div5(s5);
  end

  assign lvl7[0] = a0;
  assign lvl7[1] = a1;
  for (g = 1; g < 7; g++) begin : g_lvl7
    logic [10:0] s7;
    assign s7 = 11'(7 - g) * {3'b000, a0} + 11'(g) * {3'b000, a1};
    assign lvl7[g + 1] = div7(s7);
  end

  assign palette.alpha = (a0 <= a1) ? lvl5 : lvl7;
  assign palette.three = three;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for dxt_block_decoder: directed and random blocks checked texel by texel
`timescale 1ns / 100ps
module tb_top;
  import dxt_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int DRAIN_SLACK = 8;
  localparam int MAX_REPORTS = 20;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dxt_request_t block;
  logic texel_valid;
  dxt_result_t texel;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;

  dxt_request_t pending_blocks[$];
  dxt_result_t expected_texels[$];
  logic [1:0] format_now;
  logic [3:0] mask_now;
  logic req_taken;
  int send_idle_pct;
  int mismatches;
  int texels_seen;
  int blocks_taken;
  int blocks_per_format[4];

  dxt_block_decoder dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block(block),
    .texel_valid(texel_valid),
    .texel(texel),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS) begin
      $display("tb: mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    end
    mismatches++;
  endtask

  // builds the sixteen texels one block must produce under the given settings
  function automatic void decode_texels(input dxt_request_t req, input logic [1:0] fmt,
                                        input logic [3:0] mask);
    logic [15:0] ep[2];
    logic [7:0] pal[4][3];
    int apal[8];
    logic dxt1;
    logic three;
    int c;
    int d;
    int a0;
    int a1;
    int ci;
    int alpha_v;
    dxt_result_t t;
    ep[0] = req.colour_word[15:0];
    ep[1] = req.colour_word[31:16];
    dxt1 = !(fmt == FMT_DXT3 || fmt == FMT_DXT5);
    three = dxt1 && (ep[0] <= ep[1]);
    for (int e = 0; e < 2; e++) begin
      pal[e][0] = {ep[e][15:11], ep[e][15:13]};
      pal[e][1] = {ep[e][10:5], ep[e][10:9]};
      pal[e][2] = {ep[e][4:0], ep[e][4:2]};
    end
    for (int ch = 0; ch < 3; ch++) begin
      c = pal[0][ch];
      d = pal[1][ch];
      if (three) begin
        pal[2][ch] = 8'((c + d) / 2);
        pal[3][ch] = 8'd0;
      end else begin
        pal[2][ch] = 8'((2 * c + d) / 3);
        pal[3][ch] = 8'((c + 2 * d) / 3);
      end
    end
    a0 = req.alpha_word[7:0];
    a1 = req.alpha_word[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 <= a1) begin
      for (int k = 1; k < 5; k++) apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end else begin
      for (int k = 1; k < 7; k++) apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end
    for (int i = 0; i < 16; i++) begin
      ci = req.colour_word[32 + 2 * i +: 2];
      alpha_v = (three && ci == 3) ? 0 : 255;
      if (fmt == FMT_DXT3) begin
        alpha_v = 17 * int'(req.alpha_word[4 * i +: 4]);
      end else if (fmt == FMT_DXT5) begin
        alpha_v = apal[req.alpha_word[16 + 3 * i +: 3]];
      end
      t.texel_index = 4'(i);
      t.red = mask[MASK_RED] ? pal[ci][0] : 8'd0;
      t.green = mask[MASK_GREEN] ? pal[ci][1] : 8'd0;
      t.blue = mask[MASK_BLUE] ? pal[ci][2] : 8'd0;
      t.alpha = mask[MASK_ALPHA] ? 8'(alpha_v) : ALPHA_OPAQUE;
      t.last_texel = (4'(i) == LAST_TEXEL);
      expected_texels.push_back(t);
    end
  endfunction

  task automatic check_texel(input dxt_result_t got);
    dxt_result_t want;
    if (expected_texels.size() == 0) begin
      report_mismatch("texel with no block pending", got.texel_index, -1);
      return;
    end
    want = expected_texels.pop_front();
    texels_seen++;
    if (got.texel_index !== want.texel_index)
      report_mismatch("texel_index", got.texel_index, want.texel_index);
    if (got.red !== want.red) report_mismatch("red", got.red, want.red);
    if (got.green !== want.green) report_mismatch("green", got.green, want.green);
    if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
    if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
    if (got.last_texel !== want.last_texel)
      report_mismatch("last_texel", got.last_texel, want.last_texel);
  endtask

  // monitor: checks texels, predicts on each taken request, tracks register writes
  always @(posedge clk) begin
    if (rst) begin
      format_now <= FMT_DXT1;
      mask_now <= 4'hF;
      req_taken <= 1'b0;
    end else begin
      if (texel_valid) check_texel(texel);
      req_taken <= start && !busy;
      if (start && !busy) begin
        decode_texels(block, format_now, mask_now);
        blocks_taken++;
        blocks_per_format[format_now]++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_FORMAT) format_now <= cfg_data[1:0];
        else mask_now <= cfg_data;
      end
    end
  end

  // driver: holds a request until taken, then idles at random or sends the next
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        block <= pending_blocks.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_block(input logic [63:0] cw, input logic [63:0] aw);
    dxt_request_t req;
    req.colour_word = cw;
    req.alpha_word = aw;
    pending_blocks.push_back(req);
  endtask

  task automatic queue_random_blocks(input int n);
    logic [63:0] cw;
    logic [63:0] aw;
    for (int i = 0; i < n; i++) begin
      cw = {$urandom, $urandom};
      aw = {$urandom, $urandom};
      case ($urandom_range(7))
        0: cw[31:16] = cw[15:0];
        1: cw[31:0] = $urandom_range(1) ? 32'h0000_FFFF : 32'hFFFF_0000;
        2: aw[15:8] = aw[7:0];
        3: aw[15:0] = $urandom_range(1) ? 16'h00FF : 16'hFF00;
        default: ;
      endcase
      queue_block(cw, aw);
    end
  endtask

  // wait until every request is taken and every texel has come back
  task automatic drain;
    while (pending_blocks.size() != 0 || start || expected_texels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] fmt, input logic [3:0] mask);
    // upper data bits are don't-care for the format register
    write_reg(REG_BLOCK_FORMAT, {2'($urandom_range(3)), fmt});
    write_reg(REG_CHANNEL_MASK, mask);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    block = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 4'd0;
    send_idle_pct = 21;
    mismatches = 0;
    texels_seen = 0;
    blocks_taken = 0;
    for (int f = 0; f < 4; f++) blocks_per_format[f] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings straight out of reset: dxt1, all channels on
    queue_block(64'd0, 64'd0);
    queue_block({64{1'b1}}, {64{1'b1}});
    queue_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'd0);
    queue_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'd0);
    queue_block({32'hE4E4_E4E4, 16'h8410, 16'h8410}, 64'd0);
    queue_block({32'h1B1B_1B1B, 16'hF800, 16'h07E0}, {64{1'b1}});
    drain();
    configure(FMT_DXT1, 4'hF);
    queue_random_blocks(25);
    drain();

    configure(FMT_DXT3, 4'hF);
    queue_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'hFEDC_BA98_7654_3210);
    // endpoints that would pick the three-colour palette in dxt1
    queue_block({32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, {64{1'b1}});
    queue_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'd0);
    queue_random_blocks(25);
    drain();

    configure(FMT_DXT5, 4'hF);
    queue_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {48'o7654321076543210, 8'h00, 8'hFF});
    queue_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {48'o7654321076543210, 8'hFF, 8'h00});
    queue_block({32'h1B1B_1B1B, 16'h1234, 16'h1234}, {48'o0123456701234567, 8'h80, 8'h80});
    queue_block({32'h5A5A_5A5A, 16'h07E0, 16'hF81F}, {48'o7654321076543210, 8'h0D, 8'hC8});
    queue_block({32'hA5A5_A5A5, 16'h001F, 16'hFFE0}, {48'o7654321076543210, 8'h02, 8'h01});
    queue_random_blocks(25);
    drain();

    send_idle_pct = 68;
    // unused format code behaves as dxt1
    configure(FMT_UNUSED, 4'hF);
    queue_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {64{1'b1}});
    queue_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'hFEDC_BA98_7654_3210);
    queue_random_blocks(20);
    drain();

    configure(FMT_DXT5, 4'h0);
    queue_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {48'o7654321076543210, 8'h00, 8'hFF});
    queue_random_blocks(15);
    drain();
    configure(FMT_DXT1, 4'h5);
    queue_random_blocks(15);
    drain();
    configure(FMT_DXT3, 4'hA);
    queue_random_blocks(15);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) send_idle_pct = 0;
      configure(2'($urandom_range(3)), 4'($urandom_range(15)));
      queue_random_blocks(20);
      drain();
    end

    $display("tb: %0d blocks, %0d texels checked; per format dxt1/dxt3/dxt5/unused %0d/%0d/%0d/%0d",
             blocks_taken, texels_seen, blocks_per_format[0], blocks_per_format[1],
             blocks_per_format[2], blocks_per_format[3]);
    $display("tb: channel masks 15, 0, 5, 10 and six random settings, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout, %0d texels still expected", expected_texels.size());
    $display("tb: failure");
    $finish;
  end

endmodule
